[hdl/dec_pkg.sv]
// Shared types and constants for the difference-equation controller.
// Used by dec_csr, dec_ctrl, dec_datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dec_pkg;

   // History depths and gain register counts
   localparam int ERROR_TAPS    = 4;
   localparam int EFFORT_TAPS   = 2;
   localparam int NUM_ERR_GAINS = 4;
   localparam int NUM_EFF_GAINS = 2;
   localparam int TOTAL_TAPS    = ERROR_TAPS + EFFORT_TAPS;

   // Data widths
   localparam int DATA_W    = 16;
   localparam int ERR_W     = DATA_W + 1;
   localparam int GAIN_W    = 16;
   localparam int PROD_W    = ERR_W + GAIN_W;
   localparam int FRAC_BITS = 12;
   localparam int ACC_W     = PROD_W + $clog2(TOTAL_TAPS) + 1;
   localparam int STEP_W    = (TOTAL_TAPS > 1) ? $clog2(TOTAL_TAPS) : 1;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ERR_GAIN_0 = 3'd0,
      CSR_ERR_GAIN_1 = 3'd1,
      CSR_ERR_GAIN_2 = 3'd2,
      CSR_ERR_GAIN_3 = 3'd3,
      CSR_EFF_GAIN_0 = 3'd4,
      CSR_EFF_GAIN_1 = 3'd5,
      CSR_EFF_MIN    = 3'd6,
      CSR_EFF_MAX    = 3'd7
   } csr_index_type;

   // Register file contents seen by the datapath
   typedef struct packed {
      logic [NUM_ERR_GAINS-1:0][GAIN_W-1:0] err_gain;
      logic [NUM_EFF_GAINS-1:0][GAIN_W-1:0] eff_gain;
      logic [DATA_W-1:0]                    effort_min;
      logic [DATA_W-1:0]                    effort_max;
   } csr_regs_type;

   // Controller to datapath commands
   typedef struct packed {
      logic              load;    // capture new error, shift history, clear sum
      logic              mul;     // multiply tap selected by step
      logic              acc;     // add registered product into sum
      logic              finish;  // clamp, push effort history, load output
      logic [STEP_W-1:0] step;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic out_free;             // output register can take a result this cycle
   } dp_status_type;

endpackage

`default_nettype wire

[hdl/dec_csr.sv]
// Configuration registers: gains and clamp limits, written through a plain write port.
// Depends on dec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dec_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [dec_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire logic [dec_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output dec_pkg::csr_regs_type                    regs
);
   import dec_pkg::*;

   csr_regs_type regs_ff;
   csr_regs_type regs_in;

   // Decode the write
   always_comb begin
      regs_in = regs_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_addr))
            CSR_ERR_GAIN_0: regs_in.err_gain[0] = csr_wdata[GAIN_W-1:0];
            CSR_ERR_GAIN_1: regs_in.err_gain[1] = csr_wdata[GAIN_W-1:0];
            CSR_ERR_GAIN_2: regs_in.err_gain[2] = csr_wdata[GAIN_W-1:0];
            CSR_ERR_GAIN_3: regs_in.err_gain[3] = csr_wdata[GAIN_W-1:0];
            CSR_EFF_GAIN_0: regs_in.eff_gain[0] = csr_wdata[GAIN_W-1:0];
            CSR_EFF_GAIN_1: regs_in.eff_gain[1] = csr_wdata[GAIN_W-1:0];
            CSR_EFF_MIN:    regs_in.effort_min  = csr_wdata[DATA_W-1:0];
            CSR_EFF_MAX:    regs_in.effort_max  = csr_wdata[DATA_W-1:0];
         endcase
      end
   end

   // Hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.err_gain   <= '0;
         regs_ff.eff_gain   <= '0;
         regs_ff.effort_min <= {1'b1, {(DATA_W-1){1'b0}}};
         regs_ff.effort_max <= {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign regs = regs_ff;

endmodule

`default_nettype wire

[hdl/dec_ctrl.sv]
// Sequencer: accepts one item, steps the shared multiplier over all taps,
// then clamps and hands the result to the output register. Depends on dec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dec_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  dec_pkg::dp_status_type status,
   output dec_pkg::dp_cmd_type    cmd
);
   import dec_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type         state_ff;
   state_type         state_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cmd        = '0;
      cmd.step   = step_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            cmd.acc = (step_ff != '0);
            if (step_ff == STEP_W'(TOTAL_TAPS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            // add the last product
            cmd.acc  = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // wait for room in the output register
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_MUL && step_ff == '0))
      else $error("accepted transfer did not start the multiply sequence");

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.mul, cmd.finish}))
      else $error("load, multiply and finish commands overlap");

   a_drain_to_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |=> (state_ff == ST_FINISH))
      else $error("drain did not advance to finish");

endmodule

`default_nettype wire

[hdl/dec_datapath.sv]
// Datapath: error and effort histories, one shared 17x16 multiplier, accumulator,
// clamp and output register. Depends on dec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dec_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [dec_pkg::DATA_W-1:0]  desired_speed,
   input  wire logic [dec_pkg::DATA_W-1:0]  measured_speed,
   input  dec_pkg::csr_regs_type            regs,
   input  dec_pkg::dp_cmd_type              cmd,
   output dec_pkg::dp_status_type           status,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [dec_pkg::DATA_W-1:0]       rsp_effort,
   output logic                             rsp_clamped
);
   import dec_pkg::*;

   logic signed [ERR_W-1:0]  err_hist_ff [ERROR_TAPS];
   logic signed [DATA_W-1:0] eff_hist_ff [EFFORT_TAPS];
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic [DATA_W-1:0]        rsp_effort_ff;
   logic                     rsp_clamped_ff;
   logic                     rsp_valid_ff;

   logic signed [ERR_W-1:0]  err_new;
   logic signed [ERR_W-1:0]  opnd;
   logic signed [GAIN_W-1:0] gain;
   logic signed [ACC_W-1:0]  shifted;
   logic signed [ACC_W-1:0]  lim_lo;
   logic signed [ACC_W-1:0]  lim_hi;
   logic [DATA_W-1:0]        effort_in;
   logic                     clamped_in;
   logic                     out_free;

   // Form the new error
   assign err_new = $signed({desired_speed[DATA_W-1], desired_speed})
                  - $signed({measured_speed[DATA_W-1], measured_speed});

   // Select the tap and gain for this step; taps without a register take zero gain
   always_comb begin
      opnd = '0;
      gain = '0;
      for (int i = 0; i < ERROR_TAPS; i++) begin
         if (cmd.step == STEP_W'(i)) opnd = err_hist_ff[i];
      end
      for (int i = 0; i < EFFORT_TAPS; i++) begin
         if (cmd.step == STEP_W'(ERROR_TAPS + i)) begin
            opnd = ERR_W'(eff_hist_ff[i]);
         end
      end
      for (int i = 0; i < NUM_ERR_GAINS; i++) begin
         if (i < ERROR_TAPS && cmd.step == STEP_W'(i)) gain = $signed(regs.err_gain[i]);
      end
      for (int i = 0; i < NUM_EFF_GAINS; i++) begin
         if (i < EFFORT_TAPS && cmd.step == STEP_W'(ERROR_TAPS + i)) begin
            gain = $signed(regs.eff_gain[i]);
         end
      end
   end

   // Scale down and clamp; the lower limit is tested before the upper one
   always_comb begin
      shifted    = acc_ff >>> FRAC_BITS;
      lim_lo     = ACC_W'($signed(regs.effort_min));
      lim_hi     = ACC_W'($signed(regs.effort_max));
      effort_in  = shifted[DATA_W-1:0];
      clamped_in = 1'b0;
      if (shifted < lim_lo) begin
         effort_in  = regs.effort_min;
         clamped_in = 1'b1;
      end else if (shifted > lim_hi) begin
         effort_in  = regs.effort_max;
         clamped_in = 1'b1;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Histories
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ERROR_TAPS; i++) err_hist_ff[i] <= '0;
         for (int i = 0; i < EFFORT_TAPS; i++) eff_hist_ff[i] <= '0;
      end else begin
         if (cmd.load) begin
            for (int i = ERROR_TAPS - 1; i > 0; i--) err_hist_ff[i] <= err_hist_ff[i-1];
            err_hist_ff[0] <= err_new;
         end
         if (cmd.finish) begin
            for (int i = EFFORT_TAPS - 1; i > 0; i--) eff_hist_ff[i] <= eff_hist_ff[i-1];
            eff_hist_ff[0] <= $signed(effort_in);
         end
      end
   end

   // Multiply and accumulate
   always_ff @(posedge clock) begin
      if (cmd.mul) prod_ff <= opnd * gain;
      if (cmd.load) begin
         acc_ff <= '0;
      end else if (cmd.acc) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.finish) begin
         rsp_effort_ff  <= effort_in;
         rsp_clamped_ff <= clamped_in;
      end
   end

   assign status.out_free = out_free;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_effort      = rsp_effort_ff;
   assign rsp_clamped     = rsp_clamped_ff;

   a_finish_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over an untaken result");

   a_finish_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished result not presented");

endmodule

`default_nettype wire

[hdl/difference_equation_controller_top.sv]
// Top level of the direct-form difference-equation controller.
// Depends on dec_pkg, dec_csr, dec_ctrl and dec_datapath.
//
//   channel   direction  handshake              payload
//   req_      in         req_tvalid/req_tready  tdata: desired_speed, measured_speed
//   rsp_      out        rsp_tvalid/rsp_tready  tdata: effort; tuser: clamped
//   csr_      in         csr_wr_en              csr_addr, csr_wdata
//
// Once accepted, an item steps the single 17x16 multiplier over all six taps,
// one tap at a time; the last product is then added, and the result is clamped
// and loaded into the output register. The next item is accepted only once the
// sequencer is idle again, after the previous result has been loaded.
// Reset is synchronous and active high; it clears histories and gains and
// returns the limits to the full 16-bit range.
// A result waits in the output register while rsp_tready is low; the next item
// is accepted meanwhile and its result holds in the accumulator until the slot frees.
`timescale 1ns / 1ps
`default_nettype none

module difference_equation_controller_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [2*dec_pkg::DATA_W-1:0]          req_tdata,  // desired_speed, measured_speed
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [dec_pkg::DATA_W-1:0]                 rsp_tdata,  // effort
   output logic                                       rsp_tuser,  // clamped
   input  wire logic                                  csr_wr_en,
   input  wire logic [dec_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  wire logic [dec_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import dec_pkg::*;

   csr_regs_type  regs;
   dp_cmd_type    cmd;
   dp_status_type status;

   dec_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .regs      (regs)
   );

   dec_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dec_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .desired_speed  (req_tdata[DATA_W-1:0]),
      .measured_speed (req_tdata[2*DATA_W-1:DATA_W]),
      .regs           (regs),
      .cmd            (cmd),
      .status         (status),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_effort     (rsp_tdata),
      .rsp_clamped    (rsp_tuser)
   );

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for difference_equation_controller_top: directed and random
// speed pairs, streamed result checks against an in-bench fixed-point predictor.
// Depends on dec_pkg and the RTL of the controller only.
`timescale 1ns / 1ps

module tb_top;
   import dec_pkg::*;

   localparam int PHASE_ITEMS   = 93;
   localparam int RANDOM_PHASES = 10;
   localparam int HOLD_CYCLES   = 120;

   typedef struct packed {
      logic [DATA_W-1:0] effort;
      logic              clamped;
   } effort_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [2*DATA_W-1:0]     req_tdata = '0;   // desired_speed, measured_speed
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [DATA_W-1:0]       rsp_tdata;        // effort
   logic                    rsp_tuser;        // clamped
   logic                    csr_wr_en = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_addr = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   // Controller copy: gains, limits and histories at the block's widths
   logic signed [GAIN_W-1:0] err_gain [ERROR_TAPS]  = '{default: '0};
   logic signed [GAIN_W-1:0] eff_gain [EFFORT_TAPS] = '{default: '0};
   logic signed [DATA_W-1:0] lim_lo = 16'sh8000;
   logic signed [DATA_W-1:0] lim_hi = 16'sd32767;
   logic signed [ERR_W-1:0]  err_hist [ERROR_TAPS]  = '{default: '0};
   logic signed [DATA_W-1:0] eff_hist [EFFORT_TAPS] = '{default: '0};

   logic [2*DATA_W-1:0] pending_speeds [$];
   effort_result_type   predicted_efforts [$];

   int speeds_accepted = 0;
   int efforts_seen    = 0;
   int mismatches      = 0;
   int hold_left       = 0;
   int last_hold_mark  = -1;

   difference_equation_controller_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shift the new error in, form the exact sum, floor-shift, clamp, push the effort
   function automatic effort_result_type predict_effort(logic [DATA_W-1:0] desired,
                                                        logic [DATA_W-1:0] measured);
      longint            acc;
      longint            shifted;
      effort_result_type r;
      for (int i = ERROR_TAPS - 1; i > 0; i--) err_hist[i] = err_hist[i-1];
      err_hist[0] = $signed({desired[DATA_W-1], desired})
                  - $signed({measured[DATA_W-1], measured});
      acc = 0;
      for (int i = 0; i < ERROR_TAPS; i++)
         acc += longint'(err_gain[i]) * longint'(err_hist[i]);
      for (int i = 0; i < EFFORT_TAPS; i++)
         acc += longint'(eff_gain[i]) * longint'(eff_hist[i]);
      shifted = acc >>> FRAC_BITS;
      // lower limit is tested before the upper one
      if (shifted < longint'(lim_lo)) begin
         r.effort  = lim_lo;
         r.clamped = 1'b1;
      end else if (shifted > longint'(lim_hi)) begin
         r.effort  = lim_hi;
         r.clamped = 1'b1;
      end else begin
         r.effort  = shifted[DATA_W-1:0];
         r.clamped = 1'b0;
      end
      for (int i = EFFORT_TAPS - 1; i > 0; i--) eff_hist[i] = eff_hist[i-1];
      eff_hist[0] = r.effort;
      return r;
   endfunction

   function automatic void note_mismatch(string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at %0t ns: %s", $time, what);
   endfunction

   function automatic logic [DATA_W-1:0] pick_signed(int lo, int hi);
      int v;
      v = lo + int'($urandom_range(hi - lo));
      return v[DATA_W-1:0];
   endfunction

   function automatic logic [DATA_W-1:0] pick_extreme();
      case ($urandom_range(4))
         0: return 16'h8000;
         1: return 16'hFFFF;
         2: return 16'h0000;
         3: return 16'h0001;
         default: return 16'h7FFF;
      endcase
   endfunction

   // Random idling, with a calm window on each side
   function automatic bit sender_rests();
      if (speeds_accepted >= 500 && speeds_accepted < 620) return 1'b0;
      return $urandom_range(99) < 14;
   endfunction

   function automatic bit receiver_rests();
      if (efforts_seen >= 480 && efforts_seen < 600) return 1'b0;
      return $urandom_range(99) < 14;
   endfunction

   // Request driver: predict on each transfer, hold valid until taken
   always @(posedge clock) begin : drive_req
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted_efforts.push_back(predict_effort(req_tdata[DATA_W-1:0],
                                                       req_tdata[2*DATA_W-1:DATA_W]));
            speeds_accepted <= speeds_accepted + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_speeds.size() != 0 && !sender_rests()) begin
               req_tdata  <= pending_speeds.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-offs so the block backs up and stalls its input
   always @(posedge clock) begin : hold_rsp
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if ((speeds_accepted == 250 || speeds_accepted == 820)
                   && speeds_accepted != last_hold_mark) begin
         hold_left      <= HOLD_CYCLES;
         last_hold_mark <= speeds_accepted;
      end
   end

   // Result monitor: compare each transfer with the oldest prediction
   always @(posedge clock) begin : watch_rsp
      effort_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_efforts.size() == 0) begin
               note_mismatch($sformatf("unexpected result effort %0d clamped %0b",
                                       $signed(rsp_tdata), rsp_tuser));
            end else begin
               want = predicted_efforts.pop_front();
               if (rsp_tdata !== want.effort)
                  note_mismatch($sformatf("effort expected %0d, got %0d",
                                          $signed(want.effort), $signed(rsp_tdata)));
               if (rsp_tuser !== want.clamped)
                  note_mismatch($sformatf("clamped expected %0b, got %0b",
                                          want.clamped, rsp_tuser));
            end
            efforts_seen <= efforts_seen + 1;
         end
         rsp_tready <= (hold_left == 0) && !receiver_rests();
      end
   end

   // One register write; the block is idle whenever this runs
   task automatic write_reg(csr_index_type idx, logic [DATA_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_ERR_GAIN_0: err_gain[0] = value;
         CSR_ERR_GAIN_1: err_gain[1] = value;
         CSR_ERR_GAIN_2: err_gain[2] = value;
         CSR_ERR_GAIN_3: err_gain[3] = value;
         CSR_EFF_GAIN_0: eff_gain[0] = value;
         CSR_EFF_GAIN_1: eff_gain[1] = value;
         CSR_EFF_MIN:    lim_lo = value;
         CSR_EFF_MAX:    lim_hi = value;
      endcase
   endtask

   task automatic write_all(logic [15:0] e0, logic [15:0] e1, logic [15:0] e2,
                            logic [15:0] e3, logic [15:0] f0, logic [15:0] f1,
                            logic [15:0] lo, logic [15:0] hi);
      write_reg(CSR_ERR_GAIN_0, e0);
      write_reg(CSR_ERR_GAIN_1, e1);
      write_reg(CSR_ERR_GAIN_2, e2);
      write_reg(CSR_ERR_GAIN_3, e3);
      write_reg(CSR_EFF_GAIN_0, f0);
      write_reg(CSR_EFF_GAIN_1, f1);
      write_reg(CSR_EFF_MIN, lo);
      write_reg(CSR_EFF_MAX, hi);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic offer(logic [15:0] desired, logic [15:0] measured);
      pending_speeds.push_back({measured, desired});
   endtask

   // Wait until nothing is queued, offered or outstanding, then settle
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_speeds.size() != 0 || req_tvalid || predicted_efforts.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [15:0]        g [6];
      logic signed [15:0] lo, hi, a, b;
      logic [15:0]        d, m;
      int                 sel;
      int                 mode;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: all gains zero, effort stays zero
      offer(16'h7FFF, 16'h8000);
      offer(16'h8000, 16'h7FFF);
      offer(16'h0000, 16'h0000);
      wait_drained();

      // Unity gain on the newest error: largest errors clamp at both limits
      write_all(16'h1000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                16'h8000, 16'h7FFF);
      offer(16'h7FFF, 16'h8000);
      offer(16'h8000, 16'h7FFF);
      offer(16'h0100, 16'hFF00);
      offer(16'hFFFF, 16'h0000);
      offer(16'h0001, 16'h0000);
      offer(16'h8000, 16'h8000);
      wait_drained();

      // Largest error gains with most negative feedback gains
      write_all(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
                16'h8000, 16'h7FFF);
      offer(16'h7FFF, 16'h8000);
      offer(16'h0000, 16'h0000);
      offer(16'h8000, 16'h7FFF);
      offer(16'h0064, 16'hFF9C);
      offer(16'h0000, 16'h0000);
      wait_drained();

      // Most negative gains with inverted limits
      write_all(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                16'h0064, 16'hFF9C);
      offer(16'h03E8, 16'h0000);
      offer(16'hFC18, 16'h0000);
      offer(16'h0000, 16'h0000);
      offer(16'h0000, 16'h0000);
      wait_drained();

      // Unity feedback inside tight limits
      write_all(16'h1000, 16'h0000, 16'h0000, 16'h0000, 16'h1000, 16'h0000,
                16'hFF00, 16'h0100);
      offer(16'h012C, 16'h0000);
      offer(16'hFED4, 16'h0000);
      offer(16'h0064, 16'h0000);
      offer(16'h0000, 16'h0000);
      offer(16'h0000, 16'h0001);
      wait_drained();

      // Random phases: new settings, then a burst of speed pairs
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         mode = $urandom_range(3);
         for (int i = 0; i < 6; i++) begin
            case (mode)
               0: g[i] = pick_signed(-32768, 32767);
               1: g[i] = ($urandom_range(2) == 0) ? 16'h0000 : pick_signed(-1024, 1024);
               2: g[i] = (i < 4) ? pick_signed(-4096, 4096) : pick_signed(-1536, 1536);
               default: g[i] = ($urandom_range(5) == 0) ? 16'h1000 : pick_extreme();
            endcase
         end
         case ($urandom_range(3))
            0: begin
               lo = 16'sh8000;
               hi = 16'sd32767;
            end
            1: begin
               a  = pick_signed(-32768, 32767);
               b  = pick_signed(-32768, 32767);
               lo = (a < b) ? a : b;
               hi = (a < b) ? b : a;
            end
            2: begin
               lo = pick_signed(0, 32767);
               hi = pick_signed(-32768, -1);
            end
            default: begin
               lo = pick_extreme();
               hi = lo;
            end
         endcase
         write_all(g[0], g[1], g[2], g[3], g[4], g[5], lo, hi);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            sel = $urandom_range(99);
            if (sel < 70) begin
               d = pick_signed(-32768, 32767);
               m = pick_signed(-32768, 32767);
            end else if (sel < 85) begin
               d = pick_signed(-32768, 32767);
               m = d + pick_signed(-64, 64);
            end else begin
               d = pick_extreme();
               m = pick_extreme();
            end
            offer(d, m);
         end
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (predicted_efforts.size() != 0)
         note_mismatch($sformatf("%0d results never arrived", predicted_efforts.size()));
      if (mismatches == 0) begin
         $display("difference_equation_controller_top verification clean");
      end else begin
         $display("difference_equation_controller_top verification failed");
      end
      $finish;
   end

   // Hard stop far beyond the slowest correct run
   initial begin : watchdog
      #(2_000_000);
      $display("difference_equation_controller_top verification failed");
      $finish;
   end

endmodule
